### rtl/core/align_distribute_spans_top_defines.svh
// Assertion macros of the align and distribute spans RTL
`ifndef ALIGN_DISTRIBUTE_SPANS_TOP_DEFINES_SVH
`define ALIGN_DISTRIBUTE_SPANS_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ADS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ads: same-cycle check failed");
`define ADS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ads: next-cycle check failed");
`else
`define ADS_ASSERT_IMP(lbl, ante, cons)
`define ADS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/core/ads_pkg.sv
// Shared constants, types and helper functions of the align and distribute spans block
`default_nettype none
package ads_pkg;
	localparam int MAX_SPANS = 32;
	localparam int IDX_W     = $clog2(MAX_SPANS);
	localparam int CNT_W     = $clog2(MAX_SPANS + 1);
	localparam int DEN_W     = CNT_W + 1;
	localparam int POS_W     = 24;
	localparam int EXT_W     = 23;
	localparam int MODE_W    = 3;
	localparam int SIDX_W    = 6;
	localparam int DELTA_W   = 25;
	localparam int NUM_W     = 40;

	localparam logic signed [NUM_W-1:0] DELTA_LIMIT = NUM_W'(24'hFFFFFF);

	localparam logic [MODE_W-1:0] MODE_ALIGN_STARTS  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ALIGN_ENDS    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ALIGN_CENTERS = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DIST_STARTS   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DIST_CENTERS  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DIST_ENDS     = 3'd5;
	localparam logic [MODE_W-1:0] MODE_DIST_GAPS     = 3'd6;

	typedef struct packed {
		logic                    en;
		logic [IDX_W-1:0]        addr;
		logic signed [POS_W-1:0] position;
		logic [EXT_W-1:0]        extent;
	} span_wr_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             dropped;
	} job_t;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic [DEN_W-1:0]        den;
	} div_req_t;

	typedef struct packed {
		logic                    busy;
		logic                    done;
		logic signed [NUM_W-1:0] quo;
	} div_rsp_t;

	function automatic logic signed [NUM_W-1:0] sext_pos(input logic signed [POS_W-1:0] p);
		return {{(NUM_W-POS_W){p[POS_W-1]}}, p};
	endfunction

	function automatic logic signed [NUM_W-1:0] zext_ext(input logic [EXT_W-1:0] e);
		return {{(NUM_W-EXT_W){1'b0}}, e};
	endfunction

	function automatic logic signed [NUM_W-1:0] zext_cnt(input logic [CNT_W-1:0] c);
		return {{(NUM_W-CNT_W){1'b0}}, c};
	endfunction

	// sort key in doubled units
	function automatic logic signed [NUM_W-1:0] key2(input logic [MODE_W-1:0] m,
			input logic signed [POS_W-1:0] p, input logic [EXT_W-1:0] e);
		logic signed [NUM_W-1:0] ps;
		logic signed [NUM_W-1:0] es;
		ps = sext_pos(p);
		es = zext_ext(e);
		case (m)
			MODE_DIST_CENTERS: return (ps <<< 1) + es;
			MODE_DIST_ENDS:    return (ps + es) <<< 1;
			default:           return ps <<< 1;
		endcase
	endfunction
endpackage
`default_nettype wire

### rtl/core/ads_front.sv
// Span loader: accepts items, writes the span stores and issues one job per set
`default_nettype none
module ads_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [ads_pkg::POS_W-1:0] position,
	input  logic [ads_pkg::EXT_W-1:0]        extent,
	input  logic                             last_span,
	input  logic                             hold,
	output ads_pkg::span_wr_t                wr,
	output logic                             job_push,
	output ads_pkg::job_t                    job
);
	import ads_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             dropped_q;
	logic             accept;
	logic             room;

	assign in_stall = hold;
	assign accept   = in_valid & ~hold;
	assign room     = count_q < CNT_W'(MAX_SPANS);

	assign wr.en       = accept & room;
	assign wr.addr     = count_q[IDX_W-1:0];
	assign wr.position = position;
	assign wr.extent   = extent;

	assign job_push    = accept & last_span;
	assign job.count   = count_q + CNT_W'(room);
	assign job.dropped = dropped_q | ~room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (accept) begin
			if (last_span) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end else if (room) begin
				count_q <= count_q + CNT_W'(1);
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

### rtl/core/ads_job_fifo.sv
// Two-entry job queue between the loader and the compute sequencer
`default_nettype none
module ads_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ads_pkg::job_t push_job,
	input  logic          pop,
	output logic          not_empty,
	output ads_pkg::job_t head
);
	import ads_pkg::*;

	job_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign not_empty = cnt_q != 2'd0;
	assign head      = slot_q[rp_q];
	assign do_push   = push & (cnt_q != 2'd2);
	assign do_pop    = pop & not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule
`default_nettype wire

### rtl/core/ads_div.sv
// Bit-serial signed floor divider by a small positive divisor
`default_nettype none
module ads_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ads_pkg::div_req_t req,
	output ads_pkg::div_rsp_t rsp
);
	import ads_pkg::*;

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic                    busy_q;
	logic                    fix_q;
	logic                    done_q;
	logic [STEP_W-1:0]       cnt_q;
	logic [NUM_W-1:0]        mag_q;
	logic [DEN_W-1:0]        rem_q;
	logic [DEN_W-1:0]        den_q;
	logic                    neg_q;
	logic signed [NUM_W-1:0] quo_q;
	logic [DEN_W:0]          trial;
	logic                    ge;
	logic [DEN_W:0]          diff;

	assign trial = {rem_q, mag_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= fix_q;
			if (req.start) begin
				busy_q <= 1'b1;
				fix_q  <= 1'b0;
			end else if (busy_q) begin
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end else begin
				fix_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mag_q <= req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
			neg_q <= req.num[NUM_W-1];
			den_q <= req.den;
			rem_q <= '0;
			cnt_q <= STEP_W'(NUM_W);
		end else if (busy_q) begin
			mag_q <= {mag_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			cnt_q <= cnt_q - STEP_W'(1);
		end else if (fix_q) begin
			// round towards minus infinity for negative dividends
			if (neg_q) begin
				quo_q <= (rem_q != '0) ? -$signed(mag_q + NUM_W'(1)) : -$signed(mag_q);
			end else begin
				quo_q <= $signed(mag_q);
			end
		end
	end
endmodule
`default_nettype wire

### rtl/core/ads_back.sv
// Compute sequencer: span stores, rank sort, target arithmetic and result output
`default_nettype none
`include "align_distribute_spans_top_defines.svh"
module ads_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ads_pkg::MODE_W-1:0]    mode,
	input  ads_pkg::span_wr_t             wr,
	input  logic                          job_valid,
	input  ads_pkg::job_t                 job,
	output logic                          job_pop,
	output logic                          busy,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ads_pkg::SIDX_W-1:0]    span_index,
	output logic signed [ads_pkg::DELTA_W-1:0] delta,
	output logic                          overflow,
	output logic                          last_result
);
	import ads_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_A1_RD = 5'd1;
	localparam logic [4:0] S_A1_EX = 5'd2;
	localparam logic [4:0] S_A2_RD = 5'd3;
	localparam logic [4:0] S_A2_EX = 5'd4;
	localparam logic [4:0] S_DIV   = 5'd5;
	localparam logic [4:0] S_EMIT  = 5'd6;
	localparam logic [4:0] S_SK_RD = 5'd7;
	localparam logic [4:0] S_SK_EX = 5'd8;
	localparam logic [4:0] S_SJ_RD = 5'd9;
	localparam logic [4:0] S_SJ_EX = 5'd10;
	localparam logic [4:0] S_SW    = 5'd11;
	localparam logic [4:0] S_DI    = 5'd12;
	localparam logic [4:0] S_FR0   = 5'd13;
	localparam logic [4:0] S_FR1   = 5'd14;
	localparam logic [4:0] S_DK0   = 5'd15;
	localparam logic [4:0] S_DKM   = 5'd16;
	localparam logic [4:0] S_DW    = 5'd17;
	localparam logic [4:0] S_DG    = 5'd18;
	localparam logic [4:0] S_DEX   = 5'd19;
	localparam logic [4:0] S_DEX2  = 5'd20;
	localparam logic [4:0] S_FIN   = 5'd21;

	// span stores and sorted order
	logic signed [POS_W-1:0] start_mem  [MAX_SPANS];
	logic [EXT_W-1:0]        ext_mem    [MAX_SPANS];
	logic [IDX_W-1:0]        sorted_mem [MAX_SPANS];
	logic signed [POS_W-1:0] rd_p_q;
	logic [EXT_W-1:0]        rd_e_q;
	logic [IDX_W-1:0]        so_q;

	logic [4:0]              state_q;
	logic [4:0]              ret_q;
	logic [MODE_W-1:0]       mode_q;
	logic [CNT_W-1:0]        n_q;
	logic [CNT_W-1:0]        m_q;
	logic [CNT_W-1:0]        i_q;
	logic [CNT_W-1:0]        j_q;
	logic [CNT_W-1:0]        r_q;
	logic [CNT_W-1:0]        fr_q;
	logic [CNT_W-1:0]        rank_q;
	logic                    drop_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [NUM_W-1:0] acc_q;
	logic signed [NUM_W-1:0] keyi_q;
	logic signed [NUM_W-1:0] k0_q;
	logic signed [NUM_W-1:0] dd_q;
	logic signed [NUM_W-1:0] left0_q;
	logic signed [NUM_W-1:0] sm_q;
	logic signed [NUM_W-1:0] w_q;
	logic signed [NUM_W-1:0] g_q;
	logic signed [NUM_W-1:0] s_q;
	logic signed [NUM_W-1:0] prod_q;

	logic                    held_v_q;
	logic [IDX_W-1:0]        held_idx_q;
	logic signed [DELTA_W-1:0] held_delta_q;
	logic                    out_v_q;
	logic [IDX_W-1:0]        out_idx_q;
	logic signed [DELTA_W-1:0] out_delta_q;
	logic                    out_ovf_q;
	logic                    out_last_q;

	logic                    st_re;
	logic [IDX_W-1:0]        st_ra;
	logic signed [NUM_W-1:0] p_rd;
	logic signed [NUM_W-1:0] e_rd;
	logic signed [NUM_W-1:0] key_rd;
	logic                    last_i;
	logic                    last_j;
	logic                    is_align;
	logic                    is_gaps;
	logic                    out_free;
	logic                    q_nz;
	logic                    emit_ok;
	logic                    emit_push;
	logic                    fin_push;
	logic signed [NUM_W-1:0] sat;
	div_req_t                div_req;
	div_rsp_t                div_rsp;

	ads_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign p_rd     = sext_pos(rd_p_q);
	assign e_rd     = zext_ext(rd_e_q);
	assign key_rd   = key2(mode_q, rd_p_q, rd_e_q);
	assign last_i   = i_q == n_q - CNT_W'(1);
	assign last_j   = j_q == n_q - CNT_W'(1);
	assign is_align = mode_q <= MODE_ALIGN_CENTERS;
	assign is_gaps  = mode_q == MODE_DIST_GAPS;

	assign st_re = (state_q == S_A1_RD) || (state_q == S_A2_RD) || (state_q == S_SK_RD) ||
		(state_q == S_SJ_RD) || (state_q == S_FR1);
	assign st_ra = (state_q == S_FR1) ? so_q :
		(state_q == S_SJ_RD) ? j_q[IDX_W-1:0] : i_q[IDX_W-1:0];

	// divider feed
	always_comb begin
		div_req.start = (state_q == S_A2_EX) || (state_q == S_DEX2);
		div_req.num   = '0;
		div_req.den   = DEN_W'(1);
		if (state_q == S_A2_EX) begin
			case (mode_q)
				MODE_ALIGN_STARTS: div_req.num = acc_q - p_rd;
				MODE_ALIGN_ENDS:   div_req.num = acc_q - (p_rd + e_rd);
				default: begin
					div_req.num = acc_q - zext_cnt(n_q) * ((p_rd <<< 1) + e_rd);
					div_req.den = {n_q, 1'b0};
				end
			endcase
		end else if (is_gaps) begin
			div_req.num = prod_q + g_q * zext_cnt(r_q);
			div_req.den = {1'b0, m_q};
		end else begin
			div_req.num = prod_q + dd_q * zext_cnt(r_q);
			div_req.den = {m_q, 1'b0};
		end
	end

	always_comb begin
		if (div_rsp.quo > DELTA_LIMIT) begin
			sat = DELTA_LIMIT;
		end else if (div_rsp.quo < -DELTA_LIMIT) begin
			sat = -DELTA_LIMIT;
		end else begin
			sat = div_rsp.quo;
		end
	end

	assign out_free  = ~out_v_q | ~out_stall;
	assign q_nz      = div_rsp.quo != '0;
	assign emit_ok   = ~q_nz | ~held_v_q | out_free;
	assign emit_push = (state_q == S_EMIT) & q_nz & held_v_q & out_free;
	assign fin_push  = (state_q == S_FIN) & held_v_q & out_free;

	assign job_pop     = (state_q == S_IDLE) & job_valid;
	assign busy        = state_q != S_IDLE;
	assign out_valid   = out_v_q;
	assign span_index  = SIDX_W'(out_idx_q);
	assign delta       = out_delta_q;
	assign overflow    = out_ovf_q;
	assign last_result = out_last_q;

	// stores
	always_ff @(posedge clk) begin
		if (wr.en) begin
			start_mem[wr.addr] <= wr.position;
			ext_mem[wr.addr]   <= wr.extent;
		end
		if (st_re) begin
			rd_p_q <= start_mem[st_ra];
			rd_e_q <= ext_mem[st_ra];
		end
		if (state_q == S_SW) begin
			sorted_mem[rank_q[IDX_W-1:0]] <= i_q[IDX_W-1:0];
		end
		if (state_q == S_FR0) begin
			so_q <= sorted_mem[fr_q[IDX_W-1:0]];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			held_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			out_v_q <= emit_push | fin_push | (out_v_q & out_stall);
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						if (mode <= MODE_ALIGN_CENTERS) begin
							state_q <= S_A1_RD;
						end else if (mode <= MODE_DIST_GAPS && job.count > CNT_W'(2)) begin
							state_q <= S_SK_RD;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_A1_RD: state_q <= S_A1_EX;
				S_A1_EX: state_q <= last_i ? S_A2_RD : S_A1_RD;
				S_A2_RD: state_q <= S_A2_EX;
				S_A2_EX: state_q <= S_DIV;
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_ok) begin
						if (q_nz) begin
							held_v_q <= 1'b1;
						end
						if (is_align) begin
							state_q <= last_i ? S_FIN : S_A2_RD;
						end else begin
							state_q <= (r_q == m_q) ? S_FIN : S_FR0;
						end
					end
				end
				S_SK_RD: state_q <= S_SK_EX;
				S_SK_EX: state_q <= S_SJ_RD;
				S_SJ_RD: state_q <= S_SJ_EX;
				S_SJ_EX: state_q <= last_j ? S_SW : S_SJ_RD;
				S_SW:    state_q <= last_i ? S_DI : S_SK_RD;
				S_DI:    state_q <= S_FR0;
				S_FR0:   state_q <= S_FR1;
				S_FR1:   state_q <= ret_q;
				S_DK0:   state_q <= S_FR0;
				S_DKM:   state_q <= S_FR0;
				S_DW:    state_q <= (r_q == m_q - CNT_W'(1)) ? S_DG : S_FR0;
				S_DG:    state_q <= S_FR0;
				S_DEX:   state_q <= S_DEX2;
				S_DEX2:  state_q <= S_DIV;
				S_FIN: begin
					if (!held_v_q || out_free) begin
						held_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (emit_push) begin
			out_idx_q   <= held_idx_q;
			out_delta_q <= held_delta_q;
			out_ovf_q   <= drop_q;
			out_last_q  <= 1'b0;
		end else if (fin_push) begin
			out_idx_q   <= held_idx_q;
			out_delta_q <= held_delta_q;
			out_ovf_q   <= drop_q;
			out_last_q  <= 1'b1;
		end
		case (state_q)
			S_IDLE: begin
				if (job_valid) begin
					n_q    <= job.count;
					m_q    <= job.count - CNT_W'(1);
					drop_q <= job.dropped;
					mode_q <= mode;
					i_q    <= '0;
					acc_q  <= '0;
				end
			end
			S_A1_EX: begin
				case (mode_q)
					MODE_ALIGN_STARTS: begin
						if (i_q == '0 || p_rd < acc_q) begin
							acc_q <= p_rd;
						end
					end
					MODE_ALIGN_ENDS: begin
						if (i_q == '0 || (p_rd + e_rd) > acc_q) begin
							acc_q <= p_rd + e_rd;
						end
					end
					default: acc_q <= acc_q + (p_rd <<< 1) + e_rd;
				endcase
				i_q <= last_i ? '0 : i_q + CNT_W'(1);
			end
			S_A2_EX: idx_q <= i_q[IDX_W-1:0];
			S_EMIT: begin
				if (emit_ok) begin
					if (q_nz) begin
						held_idx_q   <= idx_q;
						held_delta_q <= sat[DELTA_W-1:0];
					end
					i_q  <= i_q + CNT_W'(1);
					r_q  <= r_q + CNT_W'(1);
					fr_q <= r_q + CNT_W'(1);
					ret_q <= S_DEX;
				end
			end
			S_SK_EX: begin
				keyi_q <= key_rd;
				j_q    <= '0;
				rank_q <= '0;
			end
			S_SJ_EX: begin
				// stable rank: earlier arrivals win ties
				if (key_rd < keyi_q || (key_rd == keyi_q && j_q < i_q)) begin
					rank_q <= rank_q + CNT_W'(1);
				end
				j_q <= j_q + CNT_W'(1);
			end
			S_SW: i_q <= i_q + CNT_W'(1);
			S_DI: begin
				fr_q  <= '0;
				ret_q <= S_DK0;
			end
			S_DK0: begin
				k0_q    <= key_rd;
				left0_q <= p_rd + e_rd;
				fr_q    <= m_q;
				ret_q   <= S_DKM;
			end
			S_DKM: begin
				dd_q  <= key_rd - k0_q;
				sm_q  <= p_rd;
				w_q   <= '0;
				r_q   <= CNT_W'(1);
				fr_q  <= CNT_W'(1);
				ret_q <= is_gaps ? S_DW : S_DEX;
			end
			S_DW: begin
				w_q   <= w_q + e_rd;
				r_q   <= r_q + CNT_W'(1);
				fr_q  <= r_q + CNT_W'(1);
				ret_q <= S_DW;
			end
			S_DG: begin
				g_q   <= sm_q - left0_q - w_q;
				s_q   <= '0;
				r_q   <= CNT_W'(1);
				fr_q  <= CNT_W'(1);
				ret_q <= S_DEX;
			end
			S_DEX: begin
				idx_q <= so_q;
				if (is_gaps) begin
					prod_q <= (left0_q + s_q - p_rd) * zext_cnt(m_q);
					s_q    <= s_q + e_rd;
				end else begin
					prod_q <= (k0_q - key_rd) * zext_cnt(m_q);
				end
			end
			default: begin
			end
		endcase
	end

	`ADS_ASSERT_IMP(a_div_free, div_req.start, !div_rsp.busy)
	`ADS_ASSERT_IMP(a_idle_no_held, state_q == S_IDLE, !held_v_q)
	`ADS_ASSERT_IMP(a_rank_range, state_q == S_SW, rank_q < n_q)
	`ADS_ASSERT_NXT(a_fin_exit, state_q == S_FIN && !held_v_q, state_q == S_IDLE)
endmodule
`default_nettype wire

### rtl/core/align_distribute_spans_top.sv
// Top level of the align and distribute spans block
`default_nettype none
// Align or evenly distribute a set of one-dimensional spans. Send the spans of a set one item
// per cycle while in_stall is low (start position and extent, Q.4) and mark the final
// one with last_span; up to MAX_SPANS spans are kept, any beyond that are dropped and every
// result of the set carries overflow. The mode register picks align starts, ends or centers,
// or distribute starts, centers, ends or gaps; write it only while the block is idle. After
// the last span the block emits, for each span whose move is nonzero, its arrival index and
// delta (floor rounded, saturated), in arrival order for align modes and in sorted order for
// distribute modes, with last_result on the final one. A run scans the spans and computes
// each delta with the bit-serial divider, which produces one quotient bit per cycle;
// distribute runs add a rank sort plus a fetch through the sorted order for each span.
// Input items are held off (in_stall) from the last span until the run has passed its final
// result into the output register; a result that waits there does not hold off new input.
module align_distribute_spans_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ads_pkg::MODE_W-1:0]        mode,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [ads_pkg::POS_W-1:0]  position,
	input  logic [ads_pkg::EXT_W-1:0]         extent,
	input  logic                              last_span,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ads_pkg::SIDX_W-1:0]        span_index,
	output logic signed [ads_pkg::DELTA_W-1:0] delta,
	output logic                              overflow,
	output logic                              last_result
);
	import ads_pkg::*;

	logic [MODE_W-1:0] mode_q;
	span_wr_t          wr;
	logic              job_push;
	job_t              push_job;
	logic              job_valid;
	job_t              head_job;
	logic              job_pop;
	logic              back_busy;
	logic              hold;

	// mode register: always ready; to be written only between runs, which the block itself does not enforce
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ALIGN_STARTS;
		end else if (cfg_valid) begin
			mode_q <= mode;
		end
	end

	// hold the loader while a set is queued or being worked on: the stores are shared
	assign hold = job_valid | back_busy;

	ads_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.position  (position),
		.extent    (extent),
		.last_span (last_span),
		.hold      (hold),
		.wr        (wr),
		.job_push  (job_push),
		.job       (push_job)
	);

	ads_job_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_job  (push_job),
		.pop       (job_pop),
		.not_empty (job_valid),
		.head      (head_job)
	);

	ads_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode_q),
		.wr          (wr),
		.job_valid   (job_valid),
		.job         (head_job),
		.job_pop     (job_pop),
		.busy        (back_busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.span_index  (span_index),
		.delta       (delta),
		.overflow    (overflow),
		.last_result (last_result)
	);
endmodule
`default_nettype wire
